@@ hdl/ros_pkg.sv @@
// Shared constants, codes and types for the ranked ordered set.
package ros_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int CMD_W       = 2;
  localparam int IN_KEY_W    = 32;
  localparam int RANK_W      = 8;
  localparam int CNT_OUT_W   = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANK   = 2'd2;

  localparam logic [RANK_W-1:0]    RANK_EMPTY = 8'hFF;
  localparam logic [CNT_OUT_W-1:0] SAT_MAX    = 7'd127;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

@@ hdl/ros_cell.sv @@
// One cell of the sorted key row: holds a key, compares it and shifts on insert.
module ros_cell
  import ros_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmp_en,
  input  logic                        shift_en,
  input  logic                        occupied,
  input  logic signed [KEY_WIDTH-1:0] cmp_key,
  input  logic signed [KEY_WIDTH-1:0] ins_key,
  input  logic signed [KEY_WIDTH-1:0] left_key,
  input  logic                        left_lt,
  output logic signed [KEY_WIDTH-1:0] key_out,
  output logic                        lt_out,
  output logic                        eq_out
);

  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic                        lt_r, lt_nxt;
  logic                        eq_r, eq_nxt;

  always_comb begin
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    key_nxt = key_r;
    if (cmp_en) begin
      lt_nxt = occupied && (key_r < cmp_key);
      eq_nxt = occupied && (key_r == cmp_key);
    end
    // keys below the new one stay; the next takes it, the ones above shift up
    if (shift_en && !lt_r) begin
      key_nxt = left_lt ? ins_key : left_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_out = key_r;
  assign lt_out  = lt_r;
  assign eq_out  = eq_r;

endmodule

@@ hdl/ros_encoder.sv @@
// Turns the row's less-than and equal flags into an insert position and a presence flag.
module ros_encoder
  import ros_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int PW      = $clog2(CAPACITY + 1)
) (
  input  logic [CAPACITY-1:0] lt_vec,
  input  logic [CAPACITY-1:0] eq_vec,
  output logic [PW-1:0]       pos,
  output logic                found
);

  logic [CAPACITY-1:0] first_ge;

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        first_ge[i] = !lt_vec[i];
      end else begin
        first_ge[i] = !lt_vec[i] && lt_vec[i-1];
      end
      if (first_ge[i]) begin
        pos = pos | PW'(i);
      end
    end
    // every cell below the key: only when the row is full
    if (first_ge == '0) begin
      pos = PW'(CAPACITY);
    end
    found = |eq_vec;
  end

endmodule

@@ hdl/ranked_ordered_set.sv @@
// An accepted item is registered with the cells' compare flags; in the execute state the
// cell row shifts on insert and the result is loaded into out_tdata. No new item is taken
// until then; a waiting result holds the item in the execute state, and so the input.
// Reset clears the key count, the state machine and the output valid; the keys in the
// cells are not cleared, as only cells below the count take part in a compare.
module ranked_ordered_set
  import ros_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] command, [33:2] key, [39:34] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] found, [8:1] rank_count, [9] full_drop, [16:10] element_count, [23:17] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PW = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]            cmd_r, cmd_nxt;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [PW-1:0]               count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]      out_data_r, out_data_nxt;

  logic [IN_KEY_W-1:0]         in_key;
  logic signed [KEY_WIDTH-1:0] key_red;
  logic                        accept;
  logic                        load;
  logic                        do_ins;
  logic                        drop;
  logic [PW-1:0]               pos;
  logic                        found;
  logic [PW-1:0]               rank_raw;
  logic [RANK_W-1:0]           rank_out;
  logic [PW-1:0]               count_after;
  logic [CNT_OUT_W-1:0]        count_out;

  logic [CAPACITY-1:0]         lt_vec;
  logic [CAPACITY-1:0]         eq_vec;
  logic [CAPACITY-1:0]         occ_vec;
  logic signed [KEY_WIDTH-1:0] cell_key [CAPACITY];

  assign in_key = in_tdata[CMD_W +: IN_KEY_W];

  generate
    if (KEY_WIDTH <= IN_KEY_W) begin : g_key_trunc
      assign key_red = in_key[KEY_WIDTH-1:0];
    end else begin : g_key_ext
      assign key_red = {{(KEY_WIDTH - IN_KEY_W){in_key[IN_KEY_W-1]}}, in_key};
    end
  endgenerate

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // row of cells, each but the first fed by its left neighbour
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ_vec[i] = (32'(count_r) > i);
      if (i == 0) begin : g_first
        ros_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .cmp_en   (accept),
          .shift_en (load && do_ins),
          .occupied (occ_vec[i]),
          .cmp_key  (key_red),
          .ins_key  (key_r),
          .left_key (key_r),
          .left_lt  (1'b1),
          .key_out  (cell_key[i]),
          .lt_out   (lt_vec[i]),
          .eq_out   (eq_vec[i])
        );
      end else begin : g_rest
        ros_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .cmp_en   (accept),
          .shift_en (load && do_ins),
          .occupied (occ_vec[i]),
          .cmp_key  (key_red),
          .ins_key  (key_r),
          .left_key (cell_key[i-1]),
          .left_lt  (lt_vec[i-1]),
          .key_out  (cell_key[i]),
          .lt_out   (lt_vec[i]),
          .eq_out   (eq_vec[i])
        );
      end
    end
  endgenerate

  ros_encoder #(.CAPACITY(CAPACITY)) u_enc (
    .lt_vec (lt_vec),
    .eq_vec (eq_vec),
    .pos    (pos),
    .found  (found)
  );

  always_comb begin
    do_ins      = (cmd_r == CMD_INSERT) && !found && (32'(count_r) < CAPACITY);
    drop        = (cmd_r == CMD_INSERT) && !found && (32'(count_r) >= CAPACITY);
    rank_raw    = pos + PW'(found);
    count_after = do_ins ? count_r + PW'(1) : count_r;

    if (cmd_r != CMD_RANK) begin
      rank_out = '0;
    end else if (count_r == '0) begin
      rank_out = RANK_EMPTY;
    end else if (32'(rank_raw) > 32'(SAT_MAX)) begin
      rank_out = RANK_W'(SAT_MAX);
    end else begin
      rank_out = RANK_W'(rank_raw);
    end

    if (32'(count_after) > 32'(SAT_MAX)) begin
      count_out = SAT_MAX;
    end else begin
      count_out = CNT_OUT_W'(count_after);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;
    load          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tdata[CMD_W-1:0];
          key_nxt   = key_red;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold the row until the output register is free
        if (!out_valid_r || out_tready) begin
          load         = 1'b1;
          count_nxt    = count_after;
          out_data_nxt = {7'd0, count_out, drop, rank_out, found};
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("key count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + PW'(1)))
    else $error("key count moved by more than one");

  a_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> ((lt_vec & (lt_vec + CAPACITY'(1))) == '0))
    else $error("less-than flags not contiguous from the lowest cell");

  a_drop_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[9]))
    else $error("item both found and dropped");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> !in_tready)
    else $error("input taken while an item is in the row");

endmodule
